// ===== design/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, codes and controller/datapath command types for the
// summed-area table rectangle-sum core.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  // Matrix dimension and derived index widths
  localparam int DIM      = 64;
  localparam int IDX_W    = $clog2(DIM);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = 1 << ADDR_W;

  // Field widths
  localparam int COORD_W  = 6;
  localparam int ELEM_W   = 16;
  localparam int ROWSUM_W = 22;
  localparam int ENTRY_W  = 28;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Table address source
  typedef enum logic [2:0] {
    ADDR_BR_BR = 3'd0,   // bottom row, right column
    ADDR_BR_TL = 3'd1,   // bottom row, column left of the rectangle
    ADDR_TL_BR = 3'd2,   // row above the rectangle, right column
    ADDR_TL_TL = 3'd3,   // row above, column left
    ADDR_ABOVE = 3'd4,   // entry above the load position
    ADDR_LOAD  = 3'd5    // load position
  } addr_sel_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_SET     = 2'd1,
    ACC_SUB_COL = 2'd2,  // subtract when the left column exists
    ACC_SUB_ROW = 2'd3   // subtract when the upper row exists
  } acc_op_t;

  typedef struct packed {
    logic      capture;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    acc_op_t   acc_op;
    logic      rowsum_step;
    logic      load_advance;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic req_is_query;
  } status_t;

  // Clamp a corner coordinate to the last row or column
  function automatic logic [IDX_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (int'(v) >= DIM) begin
      r = IDX_W'(DIM - 1);
    end else begin
      r = IDX_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/sat_ifs.sv =====
// ----------------------------------------------------------------------------
// sat_ifs
// Valid/ready channels of the summed-area table core: request word in,
// result word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_req_if import sat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [ELEM_W-1:0]  elem_value;
  logic [COORD_W-1:0]        br_col;
  logic [COORD_W-1:0]        br_row;
  logic [COORD_W-1:0]        tl_col;
  logic [COORD_W-1:0]        tl_row;

  modport source (output valid, req_type, elem_value, br_col, br_row, tl_col, tl_row,
                  input ready);
  modport sink   (input valid, req_type, elem_value, br_col, br_row, tl_col, tl_row,
                  output ready);
endinterface

interface sat_rsp_if import sat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ENTRY_W-1:0] rect_sum;
  logic                      table_complete;
  logic                      corners_ordered;

  modport source (output valid, rect_sum, table_complete, corners_ordered,
                  input ready);
  modport sink   (input valid, rect_sum, table_complete, corners_ordered,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: takes one request word at a time, steps the single table port
// through the reads and the write, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ctrl import sat_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire          out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LD_RD = 8'b0000_0010,
    S_LD_WR = 8'b0000_0100,
    S_Q_RD0 = 8'b0000_1000,
    S_Q_RD1 = 8'b0001_0000,
    S_Q_RD2 = 8'b0010_0000,
    S_Q_RD3 = 8'b0100_0000,
    S_Q_FIN = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.addr_sel     = ADDR_LOAD;
    cmd.acc_op       = ACC_HOLD;
    cmd.capture      = accept;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = status.req_is_query ? S_Q_RD0 : S_LD_RD;
        end
      end
      S_LD_RD: begin
        cmd.mem_rd      = 1'b1;
        cmd.addr_sel    = ADDR_ABOVE;
        cmd.rowsum_step = 1'b1;
        state_next      = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.mem_wr       = 1'b1;
        cmd.addr_sel     = ADDR_LOAD;
        cmd.load_advance = 1'b1;
        state_next       = S_IDLE;
      end
      S_Q_RD0: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_BR_BR;
        state_next   = S_Q_RD1;
      end
      S_Q_RD1: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_BR_TL;
        cmd.acc_op   = ACC_SET;
        state_next   = S_Q_RD2;
      end
      S_Q_RD2: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_TL_BR;
        cmd.acc_op   = ACC_SUB_COL;
        state_next   = S_Q_RD3;
      end
      S_Q_RD3: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_TL_TL;
        cmd.acc_op   = ACC_SUB_ROW;
        state_next   = S_Q_FIN;
      end
      S_Q_FIN: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Table port is never read and written in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("table read and write in the same cycle");

  // A write always follows the read of the entry above
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> $past(cmd.mem_rd) && $past(cmd.rowsum_step))
    else $error("table write without preceding read");

  // An accepted word keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while busy");

  // A result is loaded only after the last of the four reads
  a_out_after_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> ($past(cmd.addr_sel) == ADDR_TL_TL) || $past(state == S_Q_FIN))
    else $error("result loaded before all reads");

endmodule

`default_nettype wire

// ===== design/sat_datapath.sv =====
// ----------------------------------------------------------------------------
// sat_datapath
// Prefix table memory, load position counters, running row sum, query
// accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_datapath import sat_pkg::*; (
  input  wire                       clk,
  input  wire                       rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire                       req_type,
  input  wire signed [ELEM_W-1:0]   elem_value,
  input  wire [COORD_W-1:0]         br_col,
  input  wire [COORD_W-1:0]         br_row,
  input  wire [COORD_W-1:0]         tl_col,
  input  wire [COORD_W-1:0]         tl_row,
  output logic signed [ENTRY_W-1:0] rect_sum,
  output logic                      table_complete,
  output logic                      corners_ordered
);

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata;
  logic [ADDR_W-1:0]   addr;
  logic [ENTRY_W-1:0]  wdata;

  logic [IDX_W-1:0]    load_row;
  logic [IDX_W-1:0]    load_col;
  logic [ROWSUM_W-1:0] row_sum;
  logic                full_flag;

  logic [ELEM_W-1:0]   elem;
  logic [IDX_W-1:0]    q_brc, q_brr, q_tlc, q_tlr;
  logic                q_ordered;
  logic [ENTRY_W-1:0]  acc;

  logic [IDX_W-1:0]    tlc_m1, tlr_m1, row_m1;
  logic                tlc_nz, tlr_nz;
  logic [ROWSUM_W-1:0] row_sum_base;
  logic [ENTRY_W-1:0]  above;

  assign status.req_is_query = (req_type == REQ_QUERY);

  assign tlc_m1 = q_tlc - IDX_W'(1);
  assign tlr_m1 = q_tlr - IDX_W'(1);
  assign row_m1 = load_row - IDX_W'(1);
  assign tlc_nz = (q_tlc != '0);
  assign tlr_nz = (q_tlr != '0);

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elem      <= elem_value;
      q_brc     <= sat_coord(br_col);
      q_brr     <= sat_coord(br_row);
      q_tlc     <= sat_coord(tl_col);
      q_tlr     <= sat_coord(tl_row);
      q_ordered <= (tl_row <= br_row) && (tl_col <= br_col);
    end
  end

  // Table address
  always_comb begin
    case (cmd.addr_sel)
      ADDR_BR_BR: addr = {q_brr, q_brc};
      ADDR_BR_TL: addr = {q_brr, tlc_m1};
      ADDR_TL_BR: addr = {tlr_m1, q_brc};
      ADDR_TL_TL: addr = {tlr_m1, tlc_m1};
      ADDR_ABOVE: addr = {row_m1, load_col};
      default:    addr = {load_row, load_col};
    endcase
  end

  // New entry: sign-extended row sum plus the entry above
  assign above = (load_row != '0) ? rdata : '0;
  assign wdata = {{(ENTRY_W - ROWSUM_W){row_sum[ROWSUM_W-1]}}, row_sum} + above;

  // Single-port table, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  assign row_sum_base = (load_col == '0) ? '0 : row_sum;

  // Running row sum, load position and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row  <= '0;
      load_col  <= '0;
      row_sum   <= '0;
      full_flag <= 1'b0;
    end else begin
      if (cmd.rowsum_step) begin
        row_sum <= row_sum_base +
                   {{(ROWSUM_W - ELEM_W){elem[ELEM_W-1]}}, elem};
        if (load_row == '0 && load_col == '0) begin
          full_flag <= 1'b0;
        end
      end
      if (cmd.load_advance) begin
        if (load_col == IDX_W'(DIM - 1)) begin
          load_col <= '0;
          if (load_row == IDX_W'(DIM - 1)) begin
            load_row  <= '0;
            full_flag <= 1'b1;
          end else begin
            load_row <= load_row + IDX_W'(1);
          end
        end else begin
          load_col <= load_col + IDX_W'(1);
        end
      end
    end
  end

  // Inclusion-exclusion accumulator
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_SET: begin
        acc <= rdata;
      end
      ACC_SUB_COL: begin
        if (tlc_nz) begin
          acc <= acc - rdata;
        end
      end
      ACC_SUB_ROW: begin
        if (tlr_nz) begin
          acc <= acc - rdata;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Result register: add the corner term when both edges exist
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rect_sum        <= acc + ((tlc_nz && tlr_nz) ? rdata : '0);
      table_complete  <= full_flag;
      corners_ordered <= q_ordered;
    end
  end

endmodule

`default_nettype wire

// ===== design/summed_area_table_rect_sum_core.sv =====
// ----------------------------------------------------------------------------
// summed_area_table_rect_sum_core
// Builds a 2D prefix-sum table from row-major element loads and answers
// rectangle sums by inclusion-exclusion over four table entries.
//
//   channel  dir  word
//   req      in   req_type, elem_value, br_col, br_row, tl_col, tl_row
//   rsp      out  rect_sum, table_complete, corners_ordered (queries only)
//
// A load steps through accept, read of the entry above, table write.
// A query steps through accept, four reads on the single table port and
// the final add into the result register.
// The result register frees the request side: only a query that finishes
// while the previous result is still untaken waits for rsp.ready.
// Reset clears load position, row sum and completion flag, not the table.
// Entries must be read only after being written; the core does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module summed_area_table_rect_sum_core import sat_pkg::*; (
  input wire        clk,
  input wire        rst,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table and arithmetic
  sat_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req.req_type),
    .elem_value      (req.elem_value),
    .br_col          (req.br_col),
    .br_row          (req.br_row),
    .tl_col          (req.tl_col),
    .tl_row          (req.tl_row),
    .rect_sum        (rsp.rect_sum),
    .table_complete  (rsp.table_complete),
    .corners_ordered (rsp.corners_ordered)
  );

endmodule

`default_nettype wire
